// ----- hw/rtl/vse_pkg.sv -----
// Package: shared types, constants and saturation helper for the skinning engine.
`timescale 1ns / 1ps

package vse_pkg;

   localparam int JOINTS_DEF     = 64;
   localparam int INFLUENCES_DEF = 4;
   localparam int TABLE_SLOTS    = 64;

   localparam int ACC_W  = 50;   // row sums of four Q16.16 products
   localparam int SUM_W  = 35;   // weighted influence sum
   localparam int A_W    = 35;
   localparam int B_W    = 32;
   localparam int PROD_W = A_W + B_W;
   localparam int SAT_W  = 52;

   localparam logic signed [B_W-1:0] ONE_Q16    = 32'sd65536;
   localparam logic signed [B_W-1:0] SCALE_Q16  = 32'sd77332;
   localparam logic signed [SAT_W-1:0] OFFSET_Q16 = 52'sd3277;
   localparam logic signed [PROD_W-1:0] HALF_Q16 = 67'sd32768;

   typedef enum logic [1:0] {
      OP_REMAP = 2'd0,
      OP_POSE  = 2'd1,
      OP_IBIND = 2'd2,
      OP_SKIN  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      K_Q = 2'd0,   // inverse bind row
      K_T = 2'd1,   // pose row
      K_W = 2'd2,   // weight
      K_S = 2'd3    // output scale
   } kind_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [3:0] elem;   // row in [1:0], column in [3:2]
   } tag_type;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOKUP, S_CHECK, S_QMAC, S_QDRAIN, S_TMAC, S_TDRAIN,
      S_WMUL, S_WDRAIN, S_SCALE, S_SDRAIN, S_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = 52'sd2147483647;
      lo = -52'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ----- hw/rtl/vse_mul.sv -----
// Shared signed multiplier stage with its operation tag.
`timescale 1ns / 1ps

module vse_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [vse_pkg::A_W-1:0]        op_a,
   input  logic signed [vse_pkg::B_W-1:0]        op_b,
   input  vse_pkg::tag_type                      tag_in,
   output logic signed [vse_pkg::PROD_W-1:0]     prod_ff,
   output vse_pkg::tag_type                      tag_ff
);
   import vse_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

// ----- hw/rtl/vertex_skinning_engine.sv -----
// Top level: four-influence linear blend skinning engine, Q16.16.
`timescale 1ns / 1ps
//
// Input channel (req_*): one beat is either a store write or a vertex.
//   operation 0 writes the joint remap table, 1 a pose matrix word,
//   2 an inverse bind matrix word (slot*16+element), 3 skins a vertex.
//   Writes produce no result beat.
// Result channel (rsp_*): one beat per vertex, (x, -z, y) of the skinned
//   y-up position scaled by 1.18, z offset by -0.05, saturated.
// CSR (APB, csr_*): register 0 is matrix_limit (7 bits).
// Sequencing: one shared multiplier is stepped through 16 inverse-bind MACs,
//   16 pose MACs and 3 weight products per usable influence, each pass
//   followed by a pipeline drain; every influence is first looked up and
//   checked, then 3 scale products follow and drain. The three-stage
//   multiplier pipe has memory read, multiply and accumulate stages. One
//   vertex at a time; req_ready is low while a vertex is in flight.
// Reset: remap table reads unmapped, matrix_limit is 0; matrix stores are
//   undefined until written.
// Stall: the result sits in an output register; a new beat is accepted
//   while it waits, the next result holds until the old one is taken.

module vertex_skinning_engine #(
   parameter int JOINTS     = vse_pkg::JOINTS_DEF,
   parameter int INFLUENCES = vse_pkg::INFLUENCES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [5:0]         req_slot,
   input  logic [3:0]         req_element,
   input  logic signed [31:0] req_word,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_joint_ids,
   input  logic [63:0]        req_weights,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import vse_pkg::*;

   // ---------------------------------------------------------------- CSR
   logic [6:0] limit_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {25'd0, limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr) begin
         limit_ff <= csr_pwdata[6:0];
      end
   end

   // ------------------------------------------------------------ control
   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] k_ff, k_in;
   tag_type    iss;
   tag_type    tag1_ff;
   tag_type    mul_tag;
   logic       latch_q;
   logic       out_load;
   logic       pipe_empty;
   logic       usable;
   logic       req_acc;
   logic       skin_acc;

   logic [31:0]              ids_ff;
   logic [63:0]              wts_ff;
   logic signed [31:0]       pos_ff [3];
   logic [7:0]               cur_id;
   logic [15:0]              cur_w;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign skin_acc   = req_acc && (op_type'(req_operation) == OP_SKIN);
   assign pipe_empty = !tag1_ff.valid && !mul_tag.valid;
   assign cur_id     = ids_ff[8*k_ff +: 8];
   assign cur_w      = wts_ff[16*k_ff +: 16];

   always_ff @(posedge clock) begin
      if (skin_acc) begin
         ids_ff    <= req_joint_ids;
         wts_ff    <= req_weights;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
   end

   // --------------------------------------------------------- remap table
   logic                     remap_vld_ff [TABLE_SLOTS];
   logic [5:0]               remap_mem [TABLE_SLOTS];
   logic [5:0]               remap_rd_ff;
   logic                     remap_vld_rd_ff;
   logic                     remap_wr;

   assign remap_wr = req_acc && (op_type'(req_operation) == OP_REMAP);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            remap_vld_ff[i] <= 1'b0;
         end
      end else if (remap_wr) begin
         remap_vld_ff[req_slot] <= (req_word[31:6] == 26'd0);
      end
      remap_vld_rd_ff <= remap_vld_ff[cur_id[5:0]];
   end

   always_ff @(posedge clock) begin
      if (remap_wr) begin
         remap_mem[req_slot] <= req_word[5:0];
      end
      remap_rd_ff <= remap_mem[cur_id[5:0]];
   end

   assign usable = (cur_w != 16'd0) && ({24'd0, cur_id} < 32'(JOINTS))
                 && ({24'd0, cur_id} < 32'(TABLE_SLOTS)) && remap_vld_rd_ff
                 && ({1'b0, remap_rd_ff} < limit_ff);

   // ------------------------------------------------------- matrix stores
   logic [31:0] pose_mem [TABLE_SLOTS*16];
   logic [31:0] ib_mem [TABLE_SLOTS*16];
   logic [31:0] pose_rd_ff;
   logic [31:0] ib_rd_ff;
   logic        pose_wr;
   logic        ib_wr;

   assign pose_wr = req_acc && (op_type'(req_operation) == OP_POSE);
   assign ib_wr   = req_acc && (op_type'(req_operation) == OP_IBIND);

   always_ff @(posedge clock) begin
      if (pose_wr) begin
         pose_mem[{req_slot, req_element}] <= req_word;
      end
      pose_rd_ff <= pose_mem[{remap_rd_ff, iss.elem}];
   end

   always_ff @(posedge clock) begin
      if (ib_wr) begin
         ib_mem[{req_slot, req_element}] <= req_word;
      end
      ib_rd_ff <= ib_mem[{cur_id[5:0], iss.elem}];
   end

   // ----------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
         tag1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         tag1_ff  <= iss;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      iss      = '0;
      latch_q  = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (skin_acc) begin
               state_in = S_LOOKUP;
               k_in     = '0;
            end
         end
         S_LOOKUP: state_in = S_CHECK;
         S_CHECK: begin
            cnt_in = '0;
            if (usable) begin
               state_in = S_QMAC;
            end else if (k_ff == 2'(INFLUENCES - 1)) begin
               state_in = S_SCALE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_LOOKUP;
            end
         end
         S_QMAC: begin
            iss.valid = 1'b1;
            iss.kind  = K_Q;
            iss.elem  = cnt_ff;
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = S_QDRAIN;
            end
         end
         S_QDRAIN: begin
            if (pipe_empty) begin
               latch_q  = 1'b1;
               state_in = S_TMAC;
            end
         end
         S_TMAC: begin
            iss.valid = 1'b1;
            iss.kind  = K_T;
            iss.elem  = cnt_ff;
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = S_TDRAIN;
            end
         end
         S_TDRAIN: begin
            if (pipe_empty) begin
               latch_q  = 1'b1;
               state_in = S_WMUL;
            end
         end
         S_WMUL: begin
            iss.valid = 1'b1;
            iss.kind  = K_W;
            iss.elem  = {2'd0, cnt_ff[1:0]};
            if (cnt_ff == 4'd2) begin
               cnt_in   = '0;
               state_in = S_WDRAIN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_WDRAIN: begin
            if (pipe_empty) begin
               if (k_ff == 2'(INFLUENCES - 1)) begin
                  state_in = S_SCALE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_LOOKUP;
               end
            end
         end
         S_SCALE: begin
            iss.valid = 1'b1;
            iss.kind  = K_S;
            iss.elem  = {2'd0, cnt_ff[1:0]};
            if (cnt_ff == 4'd2) begin
               cnt_in   = '0;
               state_in = S_SDRAIN;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_SDRAIN: begin
            if (pipe_empty) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid || rsp_ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------ datapath
   logic signed [ACC_W-1:0]  acc_ff [4];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [31:0]       q_ff [4];
   logic signed [31:0]       res_ff [3];
   logic signed [A_W-1:0]    op_a;
   logic signed [B_W-1:0]    op_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic signed [PROD_W-1:0] rnd;
   logic signed [SAT_W-1:0]  scaled;
   logic [1:0]               row1;
   logic [1:0]               col1;
   logic [1:0]               row2;

   assign row1 = tag1_ff.elem[1:0];
   assign col1 = tag1_ff.elem[3:2];
   assign row2 = mul_tag.elem[1:0];

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (tag1_ff.kind)
         K_Q: begin
            op_a = A_W'(signed'(ib_rd_ff));
            op_b = (col1 == 2'd3) ? ONE_Q16 : pos_ff[col1];
         end
         K_T: begin
            op_a = A_W'(signed'(pose_rd_ff));
            op_b = q_ff[col1];
         end
         K_W: begin
            op_a = A_W'(q_ff[row1]);
            op_b = {16'd0, wts_ff[16*k_ff +: 16]};
         end
         K_S: begin
            // z-up swizzle: (x, -z, y)
            unique case (row1)
               2'd0:    op_a = sum_ff[0];
               2'd1:    op_a = -sum_ff[2];
               default: op_a = sum_ff[1];
            endcase
            op_b = SCALE_Q16;
         end
         default: ;
      endcase
   end

   vse_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_a    (op_a),
      .op_b    (op_b),
      .tag_in  (tag1_ff),
      .prod_ff (mul_prod),
      .tag_ff  (mul_tag)
   );

   assign rnd    = mul_prod + HALF_Q16;
   assign scaled = SAT_W'(signed'(rnd[PROD_W-1:16]))
                 - ((row2 == 2'd2) ? OFFSET_Q16 : '0);

   always_ff @(posedge clock) begin
      if (skin_acc) begin
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (latch_q) begin
         for (int i = 0; i < 4; i++) begin
            q_ff[i]   <= sat32(SAT_W'(acc_ff[i]));
            acc_ff[i] <= '0;
         end
      end else if (mul_tag.valid) begin
         unique case (mul_tag.kind)
            K_Q, K_T: acc_ff[row2] <= acc_ff[row2]
                                    + signed'(mul_prod[ACC_W+15:16]);
            K_W:      sum_ff[row2] <= sum_ff[row2]
                                    + signed'(mul_prod[SUM_W+15:16]);
            K_S:      res_ff[row2] <= sat32(scaled);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- result beat
   logic rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_out_x <= res_ff[0];
         rsp_out_y <= res_ff[1];
         rsp_out_z <= res_ff[2];
      end
   end

   // ---------------------------------------------------------- checks
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !tag1_ff.valid && !mul_tag.valid)
      else $error("multiplier pipe busy while idle");

   a_check_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> pipe_empty)
      else $error("influence check with work in flight");

   a_skin_busy: assert property (@(posedge clock) disable iff (reset)
      skin_acc |=> !req_ready)
      else $error("ready after vertex beat");

   a_infl_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> {30'd0, k_ff} < 32'(INFLUENCES))
      else $error("influence index out of range");

endmodule

// ----- sim/tb_vertex_skinning_engine.sv -----
// Testbench: random and directed checks of the skinning engine against a Q16.16 predictor.
`timescale 1ns / 1ps

// Skinning predictor and result check. It holds its own copy of the remap table,
// both matrix stores and matrix_limit.
class skin_scoreboard;
   int unsigned           mat_limit;
   bit                    remap_ok[64];
   bit [5:0]              remap_to[64];
   bit [31:0]             pose_mem[1024];
   bit [31:0]             ibind_mem[1024];
   bit                    pose_set[1024];
   bit                    ibind_set[1024];
   logic [95:0]           pending[$];
   int                    mismatches;

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint fmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   // Would this influence pass all skip tests but hit a store word never written?
   function bit hits_unwritten(int unsigned id);
      int unsigned ps;
      if (id >= vse_pkg::JOINTS_DEF || !remap_ok[id]) return 0;
      ps = remap_to[id];
      if (ps >= mat_limit) return 0;
      for (int e = 0; e < 16; e++) begin
         if (!ibind_set[id*16+e]) return 1;
         if (e % 4 != 3 && !pose_set[ps*16+e]) return 1;
      end
      return 0;
   endfunction

   function void note_beat(vse_pkg::op_type op, bit [5:0] slot, bit [3:0] elem,
                           bit [31:0] word, bit [31:0] px, bit [31:0] py,
                           bit [31:0] pz, bit [31:0] ids, bit [63:0] wts);
      longint p[3], acc[3], q[4], s, t, w, r[3], v[3];
      int unsigned id, ps;
      case (op)
         vse_pkg::OP_REMAP: begin
            remap_ok[slot] = ($signed(word) >= 0 && $signed(word) < 64);
            remap_to[slot] = remap_ok[slot] ? word[5:0] : 6'd0;
         end
         vse_pkg::OP_POSE: begin
            pose_mem[slot*16+elem] = word;
            pose_set[slot*16+elem] = 1;
         end
         vse_pkg::OP_IBIND: begin
            ibind_mem[slot*16+elem] = word;
            ibind_set[slot*16+elem] = 1;
         end
         default: begin
            p[0] = $signed(px); p[1] = $signed(py); p[2] = $signed(pz);
            acc = '{0, 0, 0};
            for (int k = 0; k < vse_pkg::INFLUENCES_DEF; k++) begin
               id = ids[8*k +: 8];
               w  = wts[16*k +: 16];
               if (w == 0 || id >= vse_pkg::JOINTS_DEF || !remap_ok[id]) continue;
               ps = remap_to[id];
               if (ps >= mat_limit) continue;
               for (int row = 0; row < 4; row++) begin
                  s = longint'($signed(ibind_mem[id*16+12+row]));
                  for (int c = 0; c < 3; c++)
                     s += fmul($signed(ibind_mem[id*16+c*4+row]), p[c]);
                  q[row] = clamp32(s);
               end
               for (int row = 0; row < 3; row++) begin
                  s = 0;
                  for (int c = 0; c < 4; c++)
                     s += fmul($signed(pose_mem[ps*16+c*4+row]), q[c]);
                  t = clamp32(s);
                  acc[row] += (t * w) >>> 16;
               end
            end
            // y-up to z-up, then scale and offset
            r[0] = acc[0]; r[1] = -acc[2]; r[2] = acc[1];
            for (int k = 0; k < 3; k++) begin
               v[k] = (r[k] * 77332 + 32768) >>> 16;
               if (k == 2) v[k] -= 3277;
               v[k] = clamp32(v[k]);
            end
            pending.push_back({v[0][31:0], v[1][31:0], v[2][31:0]});
         end
      endcase
   endfunction

   function void check_result(bit [31:0] x, bit [31:0] y, bit [31:0] z);
      logic [95:0] exp_v;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h %h %h", x, y, z);
         return;
      end
      exp_v = pending.pop_front();
      if (exp_v !== {x, y, z}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                     exp_v[95:64], exp_v[63:32], exp_v[31:0], x, y, z);
      end
   endfunction
endclass

module tb_vertex_skinning_engine;
   import vse_pkg::*;

   localparam int STALL_LIMIT = 20000;   // cycles with no beat accepted
   localparam int DRAIN_WAIT  = 250;     // extra wait after the last pending result

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [5:0]  req_slot = '0;
   logic [3:0]  req_element = '0;
   logic signed [31:0] req_word = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [31:0] req_joint_ids = '0;
   logic [63:0] req_weights = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   skin_scoreboard sb = new();
   int  send_idle_pct = 0;   // sender gap odds, percent
   int  recv_idle_pct = 0;   // receiver stall odds, percent
   int  stall_cycles = 0;
   int  sent_beats = 0;

   vertex_skinning_engine u_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Receiver: ready changes on the falling edge only.
   always @(negedge clock) rsp_ready = ($urandom_range(99) >= recv_idle_pct);

   // Monitor: both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_beat(op_type'(req_operation), req_slot, req_element, req_word,
                         req_pos_x, req_pos_y, req_pos_z, req_joint_ids, req_weights);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_out_x, rsp_out_y, rsp_out_z);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // One input beat; called and returns at a falling edge.
   task automatic send_beat(op_type op, bit [5:0] slot, bit [3:0] elem, bit [31:0] word,
                            bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                            bit [31:0] ids, bit [63:0] wts);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_operation = op; req_slot = slot; req_element = elem; req_word = word;
      req_pos_x = px; req_pos_y = py; req_pos_z = pz;
      req_joint_ids = ids; req_weights = wts;
      req_valid = 1;
      do begin
         @(posedge clock);
         taken = req_ready;
      end while (!taken);
      @(negedge clock);
      req_valid = 0;
      sent_beats++;
   endtask

   task automatic send_write(op_type op, bit [5:0] slot, bit [3:0] elem, bit [31:0] word);
      send_beat(op, slot, elem, word, $urandom, $urandom, $urandom, $urandom,
                {$urandom, $urandom});
   endtask

   // Vertex beat; influences that would read unloaded matrix words get weight zero.
   task automatic send_vertex(bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                              bit [31:0] ids, bit [63:0] wts);
      for (int k = 0; k < 4; k++)
         if (sb.hits_unwritten(ids[8*k +: 8])) wts[16*k +: 16] = '0;
      send_beat(OP_SKIN, 6'($urandom), 4'($urandom), $urandom, px, py, pz, ids, wts);
   endtask

   // Matrix word by style: 0 near identity, 1 random small, 2 extremes, 3 full random.
   function automatic bit [31:0] matrix_word(int style, int elem);
      case (style)
         0: return ((elem % 5 == 0) ? 32'sd65536 : 32'sd0) + $signed($urandom_range(8191)) - 4096;
         1: return $signed($urandom_range(524287)) - 262144;
         2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_matrix(op_type op, bit [5:0] slot, int style);
      for (int e = 0; e < 16; e++) send_write(op, slot, 4'(e), matrix_word(style, e));
   endtask

   // Register write with readback; idle block only.
   task automatic set_matrix_limit(bit [6:0] value);
      csr_paddr = '0; csr_pwdata = 32'(value); csr_pwrite = 1; csr_psel = 1;
      @(negedge clock) csr_penable = 1;
      @(negedge clock) begin
         csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      end
      sb.mat_limit = value;
      csr_psel = 1;
      @(negedge clock) csr_penable = 1;
      @(posedge clock) begin
         if (csr_prdata[6:0] !== value) begin
            sb.mismatches++;
            if (sb.mismatches <= 10)
               $display("matrix_limit readback: exp %0d got %0d", value, csr_prdata[6:0]);
         end
      end
      @(negedge clock) begin
         csr_psel = 0; csr_penable = 0;
      end
   endtask

   task automatic wait_idle();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic bit [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $signed($urandom_range(1048575)) - 524288;
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [7:0] rand_joint();
      return ($urandom_range(9) < 8) ? 8'($urandom_range(15)) : 8'($urandom);
   endfunction

   task automatic random_phase(int beats);
      int stop_at;
      int pick;
      bit [31:0] ids;
      bit [63:0] wts;
      stop_at = sent_beats + beats;
      while (sent_beats < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 7) begin
            load_matrix($urandom_range(1) ? OP_POSE : OP_IBIND, 6'($urandom_range(15)),
                        $urandom_range(3));
         end else if (pick < 14) begin
            // mostly in range, sometimes negative or past the table
            case ($urandom_range(3))
               0: send_write(OP_REMAP, 6'($urandom), 4'($urandom), $urandom);
               default: send_write(OP_REMAP, 6'($urandom_range(15)), 4'($urandom),
                                   32'($urandom_range(15)));
            endcase
         end else if (pick < 18) begin
            send_write($urandom_range(1) ? OP_POSE : OP_IBIND, 6'($urandom), 4'($urandom),
                       $urandom);
         end else begin
            for (int k = 0; k < 4; k++) begin
               ids[8*k +: 8]  = rand_joint();
               wts[16*k +: 16] = ($urandom_range(5) == 0) ? 16'd0 :
                                 ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom);
            end
            send_vertex(rand_pos(), rand_pos(), rand_pos(), ids, wts);
         end
      end
   endtask

   initial begin
      bit [6:0] limits[6] = '{7'd64, 7'd0, 7'd5, 7'd33, 7'd1, 7'd64};
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 0;

      // Fresh table: everything unmapped and limit 0, so the bare offset comes out.
      send_vertex(32'h00010000, 32'h00020000, 32'h00030000, 32'h03020100, {4{16'hFFFF}});
      wait_idle();
      set_matrix_limit(7'd64);

      // Directed: a clean joint 0 -> slot 0, an extreme joint 4 -> slot 1.
      load_matrix(OP_IBIND, 6'd0, 0);
      load_matrix(OP_POSE, 6'd0, 0);
      load_matrix(OP_IBIND, 6'd4, 2);
      load_matrix(OP_POSE, 6'd1, 2);
      send_write(OP_REMAP, 6'd0, 4'd0, 32'd0);
      send_write(OP_REMAP, 6'd4, 4'd0, 32'd1);
      send_write(OP_REMAP, 6'd1, 4'd0, 32'hFFFFFFFB);   // negative target: unmapped
      send_write(OP_REMAP, 6'd2, 4'd0, 32'd64);         // past table: unmapped
      send_write(OP_REMAP, 6'd3, 4'd0, 32'd63);         // mapped, pose slot never loaded
      send_vertex(32'h00010000, 32'hFFFF0000, 32'h00008000, 32'h00000000, 64'h0);
      send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 64'hFFFF);
      send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000000, 64'hFFFF);
      send_vertex(32'h00050000, 32'h00010000, 32'hFFFE0000, 32'h020140FF, {4{16'hFFFF}});
      send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h04040404, {4{16'hFFFF}});
      send_vertex(32'h12345678, 32'h80000000, 32'hEDCBA987, 32'h00040004, 64'h8000_0001_FFFF_0001);
      wait_idle();
      set_matrix_limit(7'd1);   // joint 4 now lands past the limit
      send_vertex(32'h00020000, 32'h00030000, 32'h00040000, 32'h00000004, 64'h0000_0000_FFFF_FFFF);
      wait_idle();

      // Random phases: idle pattern moves every two phases.
      for (int ph = 0; ph < 6; ph++) begin
         set_matrix_limit(ph == 5 ? 7'($urandom_range(64)) : limits[ph]);
         send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 48 : 0;
         recv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 19 : 0;
         random_phase(210);
         wait_idle();
      end
      recv_idle_pct = 0;
      wait_idle();

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
